### rtl/core/caseless_dbcs_substring_match_assert.svh
// Assertion macros shared by the search block.
// Both sample on the rising edge of clk and are off while arst_n is low.
`ifndef CASELESS_DBCS_SUBSTRING_MATCH_ASSERT_SVH
`define CASELESS_DBCS_SUBSTRING_MATCH_ASSERT_SVH

`define CDSM_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`define CDSM_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/core/cdsm_pkg.sv
package cdsm_pkg;

	localparam int MAX_PATTERN_DEF = 16;
	localparam int OFFSET_BITS_DEF = 32;
	localparam int PATTERN_BYTES = 16;
	localparam int MATCH_OFFSET_W = 32;
	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W = 64;
	localparam int LENGTH_W = 5;
	localparam int QUEUE_DEPTH = 2;

	localparam logic [7:0] LEAD_LOW = 8'h80;
	localparam logic [7:0] LEAD_HIGH = 8'hff;
	localparam logic [7:0] TRAIL_A_LOW = 8'h40;
	localparam logic [7:0] TRAIL_A_HIGH = 8'h7e;
	localparam logic [7:0] TRAIL_B_LOW = 8'ha1;
	localparam logic [7:0] TRAIL_B_HIGH = 8'hfe;
	localparam logic [7:0] UPPER_LOW = 8'h41;
	localparam logic [7:0] UPPER_HIGH = 8'h5a;
	localparam logic [7:0] CASE_BIT = 8'h20;

	typedef enum logic [CFG_INDEX_W-1:0] {
		CFG_PATTERN_LOW = 2'd0,
		CFG_PATTERN_HIGH = 2'd1,
		CFG_PATTERN_LENGTH = 2'd2
	} cfg_reg_t;

	typedef struct packed {
		logic [7:0] text_byte;
		logic last;
	} text_item_t;

	typedef struct packed {
		logic found;
		logic [MATCH_OFFSET_W-1:0] match_offset;
	} result_item_t;

	// One classified text step: an optional held unit, then an optional final byte.
	typedef struct packed {
		logic unit_valid;
		logic unit_dbl;
		logic [7:0] unit_fold;
		logic tail_valid;
		logic [7:0] tail_fold;
		logic last;
	} cmd_t;

	function automatic logic is_lead(input logic [7:0] c);
		return (c > LEAD_LOW) && (c < LEAD_HIGH);
	endfunction

	function automatic logic is_trail(input logic [7:0] c);
		return ((c >= TRAIL_A_LOW) && (c <= TRAIL_A_HIGH)) ||
			((c >= TRAIL_B_LOW) && (c <= TRAIL_B_HIGH));
	endfunction

	function automatic logic [7:0] fold_case(input logic [7:0] c);
		return ((c >= UPPER_LOW) && (c <= UPPER_HIGH)) ? (c | CASE_BIT) : c;
	endfunction

endpackage

### rtl/core/cdsm_front.sv
`include "caseless_dbcs_substring_match_assert.svh"

module cdsm_front import cdsm_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic text_valid,
	output logic text_ready,
	input text_item_t text,
	output logic cmd_valid,
	input logic cmd_ready,
	output cmd_t cmd
);

	logic [7:0] held_byte_q;
	logic held_valid_q;
	logic skip_q;
	logic accept;
	logic unit_valid;
	logic unit_dbl;
	logic new_skip;

	assign accept = text_valid && cmd_ready;
	assign text_ready = cmd_ready;
	assign cmd_valid = text_valid;

	assign unit_valid = held_valid_q && !skip_q;
	assign unit_dbl = is_lead(held_byte_q) && is_trail(text.text_byte);
	assign new_skip = unit_valid && unit_dbl;

	always_comb begin
		cmd.unit_valid = unit_valid;
		cmd.unit_dbl = unit_dbl;
		cmd.unit_fold = fold_case(held_byte_q);
		cmd.tail_valid = text.last && !new_skip;
		cmd.tail_fold = fold_case(text.text_byte);
		cmd.last = text.last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_valid_q <= 1'b0;
			skip_q <= 1'b0;
		end else if (accept) begin
			held_valid_q <= !text.last;
			skip_q <= !text.last && new_skip;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			held_byte_q <= text.text_byte;
		end
	end

	`CDSM_ASSERT_NOW(a_skip_needs_held, skip_q, held_valid_q, "Trail skip set without a held byte.")

endmodule

### rtl/core/cdsm_fifo.sv
`include "caseless_dbcs_substring_match_assert.svh"

module cdsm_fifo import cdsm_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic push_valid,
	output logic push_ready,
	input cmd_t push_data,
	output logic pop_valid,
	input logic pop_ready,
	output cmd_t pop_data
);

	localparam int PTR_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	cmd_t entry_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic push;
	logic pop;

	assign push_ready = (count_q != CNT_W'(QUEUE_DEPTH));
	assign pop_valid = (count_q != '0);
	assign push = push_valid && push_ready;
	assign pop = pop_valid && pop_ready;
	assign pop_data = entry_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			count_q <= count_q + CNT_W'(push) - CNT_W'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	`CDSM_ASSERT_NOW(a_empty_ptrs, count_q == '0, rd_ptr_q == wr_ptr_q, "Empty queue with unequal pointers.")
	`CDSM_ASSERT_NOW(a_count_range, 1'b1, count_q <= CNT_W'(QUEUE_DEPTH), "Queue count exceeds depth.")

endmodule

### rtl/core/cdsm_back.sv
`include "caseless_dbcs_substring_match_assert.svh"

module cdsm_back import cdsm_pkg::*; #(
	parameter int MAX_PATTERN = MAX_PATTERN_DEF,
	parameter int OFFSET_BITS = OFFSET_BITS_DEF,
	localparam int CNT_W = $clog2(MAX_PATTERN + 1)
) (
	input logic clk,
	input logic arst_n,
	input logic cmd_valid,
	output logic cmd_ready,
	input cmd_t cmd,
	input logic [CNT_W-1:0] n_eff,
	input logic [MAX_PATTERN-1:0][7:0] pat_fold,
	input logic [MAX_PATTERN-1:0] pat_usable,
	output logic result_valid,
	input logic result_ready,
	output result_item_t result
);

	localparam int IDX_W = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;

	logic [CNT_W-1:0] mi_q;
	logic [OFFSET_BITS-1:0] pos_q;
	logic reported_q;
	logic res_valid_q;
	result_item_t res_q;

	logic pop;
	logic [MAX_PATTERN-1:0] ok_unit;
	logic [MAX_PATTERN-1:0] ok_tail;
	logic [CNT_W-1:0] mi_a;
	logic [CNT_W-1:0] mi_b;
	logic [OFFSET_BITS-1:0] pos_a;
	logic [OFFSET_BITS-1:0] pos_b;
	logic done_a;
	logic done_b;
	logic hit;
	logic emit;
	logic text_idle;

	function automatic logic [CNT_W-1:0] next_index(input logic [CNT_W-1:0] mi,
			input logic [MAX_PATTERN-1:0] ok);
		logic [CNT_W-1:0] nxt;
		if (ok[mi[IDX_W-1:0]]) begin
			nxt = mi + 1'b1;
		end else if (mi == '0) begin
			nxt = '0;
		end else begin
			nxt = ok[0] ? CNT_W'(1) : '0;
		end
		return nxt;
	endfunction

	assign pop = cmd_valid && cmd_ready;
	assign cmd_ready = !res_valid_q || result_ready;
	assign result_valid = res_valid_q;
	assign result = res_q;
	assign text_idle = (mi_q == '0) && (pos_q == '0) && !reported_q;

	always_comb begin
		for (int k = 0; k < MAX_PATTERN; k++) begin
			ok_unit[k] = pat_usable[k] && !cmd.unit_dbl && (cmd.unit_fold == pat_fold[k]);
			ok_tail[k] = pat_usable[k] && (cmd.tail_fold == pat_fold[k]);
		end
	end

	always_comb begin
		mi_a = mi_q;
		pos_a = pos_q;
		done_a = 1'b0;
		if (cmd.unit_valid) begin
			mi_a = next_index(mi_q, ok_unit);
			pos_a = pos_q + (cmd.unit_dbl ? OFFSET_BITS'(2) : OFFSET_BITS'(1));
			done_a = (mi_a >= n_eff);
		end
		mi_b = mi_a;
		pos_b = pos_a;
		done_b = 1'b0;
		if (cmd.tail_valid && !done_a) begin
			mi_b = next_index(mi_a, ok_tail);
			pos_b = pos_a + OFFSET_BITS'(1);
			done_b = (mi_b >= n_eff);
		end
		hit = done_a || done_b;
		emit = !reported_q && (hit || cmd.last);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mi_q <= '0;
			pos_q <= '0;
			reported_q <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				priority if (cmd.last) begin
					mi_q <= '0;
					pos_q <= '0;
					reported_q <= 1'b0;
				end else if (!reported_q && hit) begin
					reported_q <= 1'b1;
				end else if (!reported_q) begin
					mi_q <= mi_b;
					pos_q <= pos_b;
				end else begin
				end
			end
			if (pop && emit) begin
				res_valid_q <= 1'b1;
			end else if (result_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop && emit) begin
			res_q.found <= hit;
			res_q.match_offset <= hit ?
				MATCH_OFFSET_W'(pos_b - OFFSET_BITS'(n_eff)) : '0;
		end
	end

	`CDSM_ASSERT_NEXT(a_last_clears, pop && cmd.last, text_idle, "Text state kept after last.")
	`CDSM_ASSERT_NOW(a_index_range, !reported_q, mi_q < CNT_W'(MAX_PATTERN), "Index out of range.")

endmodule

### rtl/core/caseless_dbcs_substring_match.sv
// The item that decides a result is written into the command queue; the match stage
// pops it and loads the output register; a result still held there stalls the pop.
// Throughput: one text byte per cycle while results drain, set by the match stage that
// handles a held unit and a final byte together; a two-entry queue decouples it.
// Reset clears the pattern to zero, the pattern length to one and all text state.
module caseless_dbcs_substring_match import cdsm_pkg::*; #(
	parameter int MAX_PATTERN = MAX_PATTERN_DEF,
	parameter int OFFSET_BITS = OFFSET_BITS_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic text_valid,
	output logic text_ready,
	input text_item_t text,
	output logic result_valid,
	input logic result_ready,
	output result_item_t result,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [CFG_INDEX_W-1:0] cfg_index,
	input logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int CNT_W = $clog2(MAX_PATTERN + 1);

	logic [CFG_DATA_W-1:0] pattern_low_q;
	logic [CFG_DATA_W-1:0] pattern_high_q;
	logic [LENGTH_W-1:0] pattern_length_q;

	logic [2*CFG_DATA_W-1:0] pattern_bits;
	logic [7:0] pat_byte [PATTERN_BYTES+1];
	logic [CNT_W-1:0] n_eff;
	logic [MAX_PATTERN-1:0][7:0] pat_fold;
	logic [MAX_PATTERN-1:0] pat_usable;
	logic pair;

	logic front_valid;
	logic front_ready;
	cmd_t front_cmd;
	logic back_valid;
	logic back_ready;
	cmd_t back_cmd;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pattern_low_q <= '0;
			pattern_high_q <= '0;
			pattern_length_q <= LENGTH_W'(1);
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_PATTERN_LOW: begin
					pattern_low_q <= cfg_data;
				end
				CFG_PATTERN_HIGH: begin
					pattern_high_q <= cfg_data;
				end
				CFG_PATTERN_LENGTH: begin
					pattern_length_q <= cfg_data[LENGTH_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		priority if (pattern_length_q == '0) begin
			n_eff = CNT_W'(1);
		end else if (pattern_length_q > LENGTH_W'(MAX_PATTERN)) begin
			n_eff = CNT_W'(MAX_PATTERN);
		end else begin
			n_eff = CNT_W'(pattern_length_q);
		end
	end

	assign pattern_bits = {pattern_high_q, pattern_low_q};

	// A pattern position that starts a double-byte character can never match.
	always_comb begin
		pair = 1'b0;
		for (int k = 0; k < PATTERN_BYTES; k++) begin
			pat_byte[k] = pattern_bits[8*k +: 8];
		end
		pat_byte[PATTERN_BYTES] = '0;
		for (int k = 0; k < MAX_PATTERN; k++) begin
			pair = (CNT_W'(k + 1) < n_eff) && is_lead(pat_byte[k]) && is_trail(pat_byte[k+1]);
			pat_fold[k] = fold_case(pat_byte[k]);
			pat_usable[k] = (CNT_W'(k) < n_eff) && !pair;
		end
	end

	cdsm_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.text_valid(text_valid),
		.text_ready(text_ready),
		.text(text),
		.cmd_valid(front_valid),
		.cmd_ready(front_ready),
		.cmd(front_cmd)
	);

	cdsm_fifo u_fifo (
		.clk(clk),
		.arst_n(arst_n),
		.push_valid(front_valid),
		.push_ready(front_ready),
		.push_data(front_cmd),
		.pop_valid(back_valid),
		.pop_ready(back_ready),
		.pop_data(back_cmd)
	);

	cdsm_back #(
		.MAX_PATTERN(MAX_PATTERN),
		.OFFSET_BITS(OFFSET_BITS)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.cmd_valid(back_valid),
		.cmd_ready(back_ready),
		.cmd(back_cmd),
		.n_eff(n_eff),
		.pat_fold(pat_fold),
		.pat_usable(pat_usable),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.result(result)
	);

endmodule

### sim/tb.sv
module tb;
	import cdsm_pkg::*;

	localparam logic [CFG_INDEX_W-1:0] CFG_UNMAPPED = 2'd3;
	localparam int RANDOM_ITEMS = 1600;
	localparam int CALM_ITEMS = 1350;
	localparam int PHASE_ITEMS = 60;
	localparam int BURST_TEXTS = 40;
	localparam int SETTLE_CYCLES = 8;
	localparam int HOLD_OFF_CYCLES = 80;
	localparam int CYCLE_LIMIT = 400000;

	typedef struct packed {
		logic is_cfg;
		logic [CFG_INDEX_W-1:0] reg_index;
		logic [CFG_DATA_W-1:0] reg_data;
		logic [7:0] text_byte;
		logic last;
		logic typed;
		logic found;
		logic [MATCH_OFFSET_W-1:0] offset;
	} plan_row_t;

	logic clk;
	logic arst_n;
	logic text_valid;
	logic text_ready;
	text_item_t text;
	logic result_valid;
	logic result_ready;
	result_item_t result;
	logic cfg_valid;
	logic cfg_ready;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	logic [CFG_DATA_W-1:0] pattern_lo;
	logic [CFG_DATA_W-1:0] pattern_hi;
	logic [LENGTH_W-1:0] pattern_len;
	logic [4:0] cur_index;
	logic [7:0] held_text;
	bit held_ok;
	bit trail_pending;
	logic [MATCH_OFFSET_W-1:0] text_pos;
	bit text_done;

	result_item_t expected_reports[$];
	result_item_t want_report;
	int mismatches = 0;
	int cycle_count = 0;
	int items_sent = 0;
	bit gappy = 1'b1;
	bit calm = 1'b0;
	bit hold_off_req = 1'b0;
	bit hold_active = 1'b0;

	plan_row_t directed_plan [32] = '{
		'{1'b0, CFG_PATTERN_LOW, 64'h0, 8'h00, 1'b1, 1'b1, 1'b1, 32'd0},
		'{1'b0, CFG_PATTERN_LOW, 64'h0, 8'hff, 1'b1, 1'b1, 1'b0, 32'd0},
		'{1'b1, CFG_PATTERN_LOW, 64'h634261, 8'h00, 1'b0, 1'b0, 1'b0, 32'd0},
		'{1'b1, CFG_PATTERN_LENGTH, 64'd3, 8'h00, 1'b0, 1'b0, 1'b0, 32'd0},
		'{1'b0, CFG_PATTERN_LOW, 64'h0, 8'h78, 1'b0, 1'b0, 1'b0, 32'd0},
		'{1'b0, CFG_PATTERN_LOW, 64'h0, 8'h41, 1'b0, 1'b0, 1'b0, 32'd0},
		'{1'b0, CFG_PATTERN_LOW, 64'h0, 8'h62, 1'b0, 1'b0, 1'b0, 32'd0},
		'{1'b0, CFG_PATTERN_LOW, 64'h0, 8'h43, 1'b1, 1'b1, 1'b1, 32'd1},
		'{1'b0, CFG_PATTERN_LOW, 64'h0, 8'h81, 1'b0, 1'b0, 1'b0, 32'd0},
		'{1'b0, CFG_PATTERN_LOW, 64'h0, 8'h40, 1'b0, 1'b0, 1'b0, 32'd0},
		'{1'b0, CFG_PATTERN_LOW, 64'h0, 8'h61, 1'b0, 1'b0, 1'b0, 32'd0},
		'{1'b0, CFG_PATTERN_LOW, 64'h0, 8'h62, 1'b0, 1'b0, 1'b0, 32'd0},
		'{1'b0, CFG_PATTERN_LOW, 64'h0, 8'h63, 1'b0, 1'b0, 1'b0, 32'd0},
		'{1'b0, CFG_PATTERN_LOW, 64'h0, 8'h7a, 1'b1, 1'b0, 1'b0, 32'd0},
		'{1'b0, CFG_PATTERN_LOW, 64'h0, 8'h61, 1'b0, 1'b0, 1'b0, 32'd0},
		'{1'b0, CFG_PATTERN_LOW, 64'h0, 8'h62, 1'b0, 1'b0, 1'b0, 32'd0},
		'{1'b0, CFG_PATTERN_LOW, 64'h0, 8'h63, 1'b0, 1'b0, 1'b0, 32'd0},
		'{1'b0, CFG_PATTERN_LOW, 64'h0, 8'h71, 1'b0, 1'b0, 1'b0, 32'd0},
		'{1'b0, CFG_PATTERN_LOW, 64'h0, 8'h72, 1'b1, 1'b0, 1'b0, 32'd0},
		'{1'b0, CFG_PATTERN_LOW, 64'h0, 8'h61, 1'b0, 1'b0, 1'b0, 32'd0},
		'{1'b0, CFG_PATTERN_LOW, 64'h0, 8'h61, 1'b0, 1'b0, 1'b0, 32'd0},
		'{1'b0, CFG_PATTERN_LOW, 64'h0, 8'h62, 1'b0, 1'b0, 1'b0, 32'd0},
		'{1'b0, CFG_PATTERN_LOW, 64'h0, 8'h63, 1'b1, 1'b0, 1'b0, 32'd0},
		'{1'b1, CFG_PATTERN_LOW, 64'h41, 8'h00, 1'b0, 1'b0, 1'b0, 32'd0},
		'{1'b1, CFG_PATTERN_LENGTH, 64'd0, 8'h00, 1'b0, 1'b0, 1'b0, 32'd0},
		'{1'b0, CFG_PATTERN_LOW, 64'h0, 8'h61, 1'b1, 1'b1, 1'b1, 32'd0},
		'{1'b1, CFG_PATTERN_HIGH, 64'hffff_ffff_ffff_ffff, 8'h00, 1'b0, 1'b0, 1'b0, 32'd0},
		'{1'b1, CFG_UNMAPPED, 64'hffff_ffff_ffff_ffff, 8'h00, 1'b0, 1'b0, 1'b0, 32'd0},
		'{1'b0, CFG_PATTERN_LOW, 64'h0, 8'h41, 1'b1, 1'b1, 1'b1, 32'd0},
		'{1'b1, CFG_PATTERN_LENGTH, 64'd31, 8'h00, 1'b0, 1'b0, 1'b0, 32'd0},
		'{1'b0, CFG_PATTERN_LOW, 64'h0, 8'h81, 1'b0, 1'b0, 1'b0, 32'd0},
		'{1'b0, CFG_PATTERN_LOW, 64'h0, 8'hfe, 1'b1, 1'b0, 1'b0, 32'd0}
	};

	caseless_dbcs_substring_match dut (
		.clk(clk),
		.arst_n(arst_n),
		.text_valid(text_valid),
		.text_ready(text_ready),
		.text(text),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.result(result),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	function automatic int used_length();
		int n;
		n = pattern_len;
		if (n == 0) n = 1;
		if (n > MAX_PATTERN_DEF) n = MAX_PATTERN_DEF;
		return n;
	endfunction

	function automatic logic [7:0] pattern_at(input int k);
		if (k < 8) return pattern_lo[8*k +: 8];
		return pattern_hi[8*(k-8) +: 8];
	endfunction

	function automatic bit lead_byte(input logic [7:0] c);
		return c > LEAD_LOW && c < LEAD_HIGH;
	endfunction

	function automatic bit trail_byte(input logic [7:0] c);
		return (c >= TRAIL_A_LOW && c <= TRAIL_A_HIGH) || (c >= TRAIL_B_LOW && c <= TRAIL_B_HIGH);
	endfunction

	function automatic logic [7:0] caseless(input logic [7:0] c);
		if (c >= 8'h41 && c <= 8'h5a) return c + 8'h20;
		return c;
	endfunction

	function automatic bit pattern_pair_at(input int k);
		if (k + 1 >= used_length()) return 1'b0;
		return lead_byte(pattern_at(k)) && trail_byte(pattern_at(k + 1));
	endfunction

	function automatic void clear_text_state();
		cur_index = '0;
		held_text = '0;
		held_ok = 1'b0;
		trail_pending = 1'b0;
		text_pos = '0;
		text_done = 1'b0;
	endfunction

	function automatic void reset_model();
		pattern_lo = '0;
		pattern_hi = '0;
		pattern_len = 5'd1;
		clear_text_state();
	endfunction

	// A unit that misses a partial match restarts it and is tried once more at the start.
	function automatic bit consume_unit(input logic [7:0] c, input bit pair);
		int n;
		bit hit;
		n = used_length();
		hit = 1'b0;
		for (int t = 0; t < 2; t++) begin
			hit = !pair && cur_index < n && !pattern_pair_at(cur_index) &&
				caseless(c) == caseless(pattern_at(cur_index));
			if (hit || cur_index == 0) break;
			cur_index = '0;
		end
		if (hit) cur_index++;
		text_pos = text_pos + (pair ? 2 : 1);
		return cur_index >= n;
	endfunction

	function automatic bit predict_search(input text_item_t it, output result_item_t due);
		bit hit;
		bit pair;
		hit = 1'b0;
		due = '0;
		if (text_done) begin
			if (it.last) clear_text_state();
			return 1'b0;
		end
		if (held_ok) begin
			if (trail_pending) begin
				trail_pending = 1'b0;
			end else begin
				pair = lead_byte(held_text) && trail_byte(it.text_byte);
				hit = consume_unit(held_text, pair);
				if (pair) trail_pending = 1'b1;
			end
		end
		held_text = it.text_byte;
		held_ok = 1'b1;
		if (!hit && it.last && !trail_pending) hit = consume_unit(it.text_byte, 1'b0);
		if (hit) begin
			due.found = 1'b1;
			due.match_offset = text_pos - cur_index;
			if (it.last) clear_text_state();
			else text_done = 1'b1;
			return 1'b1;
		end
		if (it.last) begin
			clear_text_state();
			return 1'b1;
		end
		return 1'b0;
	endfunction

	function automatic int idle_gap();
		if (calm || !gappy || $urandom_range(0, 4) != 0) return 0;
		return int'($urandom_range(1, 14));
	endfunction

	function automatic logic [7:0] letter_pick();
		logic [7:0] letter;
		letter = 8'($urandom_range(0, 25));
		return ($urandom_range(0, 1) != 0) ? 8'h41 + letter : 8'h61 + letter;
	endfunction

	function automatic logic [7:0] filler_byte();
		case ($urandom_range(0, 9))
			0, 1, 2, 3: return letter_pick();
			4, 5: return 8'($urandom_range(8'h81, 8'hfe));
			6: begin
				if ($urandom_range(0, 1) != 0) return 8'($urandom_range(8'h40, 8'h7e));
				return 8'($urandom_range(8'ha1, 8'hfe));
			end
			7: return ($urandom_range(0, 1) != 0) ? 8'h00 : 8'hff;
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	function automatic logic [7:0] pattern_pick();
		case ($urandom_range(0, 7))
			0, 1, 2, 3, 4: return letter_pick();
			5: return 8'h30 + 8'($urandom_range(0, 9));
			default: return filler_byte();
		endcase
	endfunction

	function automatic logic [7:0] flip_case(input logic [7:0] b);
		if ((b | 8'h20) >= 8'h61 && (b | 8'h20) <= 8'h7a && $urandom_range(0, 1) != 0)
			return b ^ 8'h20;
		return b;
	endfunction

	task automatic drive_text(input text_item_t it, input bit typed, input result_item_t want);
		int gap;
		result_item_t due;
		gap = idle_gap();
		if (gap > 0) begin
			text_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		text <= it;
		text_valid <= 1'b1;
		do @(posedge clk); while (text_ready !== 1'b1);
		items_sent++;
		calm = items_sent >= CALM_ITEMS;
		if (predict_search(it, due) || typed) expected_reports.push_back(typed ? want : due);
	endtask

	task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		cfg_index <= idx;
		cfg_data <= val;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (cfg_ready !== 1'b1);
		case (idx)
			CFG_PATTERN_LOW: pattern_lo = val;
			CFG_PATTERN_HIGH: pattern_hi = val;
			CFG_PATTERN_LENGTH: pattern_len = val[LENGTH_W-1:0];
			default: ;
		endcase
	endtask

	// Texts that already reported a match give no result at their last byte, so the pipe may still be busy.
	task automatic settle();
		text_valid <= 1'b0;
		while (expected_reports.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic load_pattern(input int phase);
		logic [CFG_DATA_W-1:0] lo;
		logic [CFG_DATA_W-1:0] hi;
		logic [CFG_DATA_W-1:0] len_word;
		logic [LENGTH_W-1:0] len;
		int r;
		for (int k = 0; k < 8; k++) begin
			lo[8*k +: 8] = pattern_pick();
			hi[8*k +: 8] = pattern_pick();
		end
		r = $urandom_range(0, 19);
		if (r == 0) len = '0;
		else if (r == 1) len = 5'($urandom_range(17, 31));
		else if (r == 2) len = 5'd16;
		else len = 5'($urandom_range(1, 8));
		if (phase == 0) begin
			lo = '1;
			hi = '1;
			len = 5'd16;
		end
		if (phase == 1) begin
			lo = '0;
			hi = '0;
			len = 5'd1;
		end
		if (phase == 2) len = 5'd31;
		len_word = {$urandom, $urandom};
		len_word[LENGTH_W-1:0] = len;
		settle();
		write_reg(CFG_PATTERN_LOW, lo);
		write_reg(CFG_PATTERN_HIGH, hi);
		write_reg(CFG_PATTERN_LENGTH, len_word);
		if ($urandom_range(0, 5) == 0) write_reg(CFG_UNMAPPED, {$urandom, $urandom});
		cfg_valid <= 1'b0;
	endtask

	// Mostly texts that carry the pattern in mixed case, sometimes after a broken prefix.
	task automatic send_text_run();
		logic [7:0] body[$];
		text_item_t it;
		int span;
		int cut;
		span = used_length();
		cut = int'($urandom_range(1, span));
		repeat ($urandom_range(0, 5)) body.push_back(filler_byte());
		if ($urandom_range(0, 4) != 0) begin
			if ($urandom_range(0, 3) == 0)
				for (int k = 0; k < cut; k++) body.push_back(flip_case(pattern_at(k)));
			for (int k = 0; k < span; k++) body.push_back(flip_case(pattern_at(k)));
		end
		repeat ($urandom_range(0, 4)) body.push_back(filler_byte());
		if (body.size() == 0) body.push_back(filler_byte());
		foreach (body[k]) begin
			it.text_byte = body[k];
			it.last = (k == body.size() - 1);
			drive_text(it, 1'b0, '0);
		end
	endtask

	initial begin
		plan_row_t row;
		text_item_t it;
		result_item_t want;
		bit cfg_open;
		int phase;
		int phase_start;
		text_valid <= 1'b0;
		text <= '0;
		cfg_valid <= 1'b0;
		cfg_index <= '0;
		cfg_data <= '0;
		arst_n <= 1'b0;
		reset_model();
		cfg_open = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (directed_plan[i]) begin
			row = directed_plan[i];
			if (row.is_cfg) begin
				if (!cfg_open) settle();
				write_reg(row.reg_index, row.reg_data);
				cfg_open = 1'b1;
			end else begin
				if (cfg_open) cfg_valid <= 1'b0;
				cfg_open = 1'b0;
				it.text_byte = row.text_byte;
				it.last = row.last;
				want.found = row.found;
				want.match_offset = row.offset;
				drive_text(it, row.typed, want);
			end
		end
		items_sent = 0;
		phase = 0;
		while (items_sent < RANDOM_ITEMS) begin
			load_pattern(phase);
			gappy = $urandom_range(0, 2) != 0;
			if (phase == 3) begin
				// Results pile up behind a stalled receiver until the input backs up.
				gappy = 1'b0;
				hold_off_req = 1'b1;
				wait (hold_active);
				repeat (BURST_TEXTS) begin
					it.text_byte = 8'($urandom);
					it.last = 1'b1;
					drive_text(it, 1'b0, '0);
				end
			end else begin
				phase_start = items_sent;
				while (items_sent - phase_start < PHASE_ITEMS) send_text_run();
			end
			phase++;
		end
		settle();
		if (mismatches == 0) begin
			$display("caseless_dbcs_substring_match regression: pass");
		end else begin
			$display("caseless_dbcs_substring_match regression: fail");
		end
		$finish;
	end

	initial begin
		result_ready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			if (hold_off_req) begin
				hold_active = 1'b1;
				result_ready <= 1'b0;
				repeat (HOLD_OFF_CYCLES) @(posedge clk);
				hold_off_req = 1'b0;
				hold_active = 1'b0;
			end else if (!calm && $urandom_range(0, 3) == 0) begin
				result_ready <= 1'b0;
				repeat ($urandom_range(1, 14)) @(posedge clk);
			end else begin
				result_ready <= 1'b1;
				repeat ($urandom_range(1, 20)) @(posedge clk);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && result_valid && result_ready) begin
			if (expected_reports.size() == 0) begin
				$error("result item with no expectation: found %0d, match_offset %0d",
					result.found, result.match_offset);
				mismatches++;
			end else begin
				want_report = expected_reports.pop_front();
				if (result.found !== want_report.found) begin
					$error("found: expected %0d, actual %0d", want_report.found, result.found);
					mismatches++;
				end
				if (result.match_offset !== want_report.match_offset) begin
					$error("match_offset: expected %0d, actual %0d",
						want_report.match_offset, result.match_offset);
					mismatches++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("caseless_dbcs_substring_match regression: fail");
			$finish;
		end
	end

endmodule
